### hw/rtl/illa_pkg.sv
// Shared types, constants and the microcode program of the linked list allocator.
package illa_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int LINK_W    = $clog2(ENTRIES + 1);
  localparam int CMD_W     = 2;
  localparam int ID_W      = 4;
  localparam int STATUS_W  = 2;
  localparam int GRANT_W   = 4;
  localparam int HEAD_W    = 5;
  localparam int FOLLOW_W  = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int STEP_W    = 4;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(ENTRIES);

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_REINIT  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_ENTRY = 2'd2
  } status_e;

  // datapath control word fields
  typedef enum logic [1:0] {E_KEEP, E_FH, E_ID} e_src_e;
  typedef enum logic [1:0] {CHK_NONE, CHK_FREE_EMPTY, CHK_BAD_RELEASE, CHK_BAD_QUERY} chk_e;
  typedef enum logic {NXA_E, NXA_P} nx_addr_e;
  typedef enum logic [1:0] {NXD_N, NXD_AH, NXD_FH} nx_data_e;
  typedef enum logic [1:0] {PVA_N, PVA_E, PVA_AH, PVA_FH} pv_addr_e;
  typedef enum logic [1:0] {PVD_NIL, PVD_E, PVD_P_OR_NIL} pv_data_e;
  typedef enum logic [1:0] {FH_KEEP, FH_N, FH_E, FH_ZERO} fh_op_e;
  typedef enum logic [1:0] {AH_KEEP, AH_E, AH_N_IF_HEAD, AH_NIL} ah_op_e;
  typedef enum logic [1:0] {USE_KEEP, USE_SET, USE_CLEAR, USE_CLEAR_ALL} use_op_e;

  typedef struct packed {
    e_src_e   e_src;
    chk_e     chk;
    logic     nx_we;
    nx_addr_e nx_addr;
    nx_data_e nx_data;
    logic     pv_we;
    pv_addr_e pv_addr;
    pv_data_e pv_data;
    fh_op_e   fh_op;
    ah_op_e   ah_op;
    use_op_e  use_op;
    logic     links_clear;
    logic     grant;
    logic     fol_load;
    logic     done;
  } ctrl_t;

  // datapath conditions seen by the sequencer
  typedef struct packed {
    logic fh_nil;
    logic entry_bad;
  } flags_t;

  // sequencer verdict for the current step
  typedef struct packed {
    logic    exec;
    logic    finish;
    logic    fail;
    status_e status;
  } seq_t;

  typedef struct packed {
    logic [FOLLOW_W-1:0] following;
    logic [HEAD_W-1:0]   list_head;
    logic [GRANT_W-1:0]  granted;
    logic [STATUS_W-1:0] status;
  } res_t;

  localparam step_t STEP_REINIT  = 4'd0;
  localparam step_t STEP_ALLOC   = 4'd1;
  localparam step_t STEP_RELEASE = 4'd5;
  localparam step_t STEP_QUERY   = 4'd9;

  function automatic step_t entry_step(cmd_e cmd);
    step_t s;
    case (cmd)
      CMD_REINIT:  s = STEP_REINIT;
      CMD_ALLOC:   s = STEP_ALLOC;
      CMD_RELEASE: s = STEP_RELEASE;
      CMD_QUERY:   s = STEP_QUERY;
      default:     s = STEP_REINIT;
    endcase
    return s;
  endfunction

  // microcode program
  function automatic ctrl_t ucode_word(step_t s);
    ctrl_t c;
    c = '0;
    case (s)
      STEP_REINIT: begin
        c.links_clear = 1'b1;
        c.fh_op       = FH_ZERO;
        c.ah_op       = AH_NIL;
        c.use_op      = USE_CLEAR_ALL;
        c.done        = 1'b1;
      end
      // allocate: take free head, read its links
      STEP_ALLOC: begin
        c.e_src = E_FH;
        c.chk   = CHK_FREE_EMPTY;
      end
      STEP_ALLOC + step_t'(1): begin
        c.nx_we   = 1'b1;
        c.nx_addr = NXA_E;
        c.nx_data = NXD_AH;
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_N;
        c.pv_data = PVD_NIL;
        c.fh_op   = FH_N;
      end
      STEP_ALLOC + step_t'(2): begin
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_E;
        c.pv_data = PVD_NIL;
      end
      STEP_ALLOC + step_t'(3): begin
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_AH;
        c.pv_data = PVD_E;
        c.ah_op   = AH_E;
        c.use_op  = USE_SET;
        c.grant   = 1'b1;
        c.done    = 1'b1;
      end
      // release: unlink from active list, push on free list
      STEP_RELEASE: begin
        c.e_src = E_ID;
        c.chk   = CHK_BAD_RELEASE;
      end
      STEP_RELEASE + step_t'(1): begin
        c.nx_we   = 1'b1;
        c.nx_addr = NXA_P;
        c.nx_data = NXD_N;
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_N;
        c.pv_data = PVD_P_OR_NIL;
        c.ah_op   = AH_N_IF_HEAD;
      end
      STEP_RELEASE + step_t'(2): begin
        c.nx_we   = 1'b1;
        c.nx_addr = NXA_E;
        c.nx_data = NXD_FH;
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_E;
        c.pv_data = PVD_NIL;
      end
      STEP_RELEASE + step_t'(3): begin
        c.pv_we   = 1'b1;
        c.pv_addr = PVA_FH;
        c.pv_data = PVD_E;
        c.fh_op   = FH_E;
        c.use_op  = USE_CLEAR;
        c.done    = 1'b1;
      end
      STEP_QUERY: begin
        c.e_src = E_ID;
        c.chk   = CHK_BAD_QUERY;
      end
      STEP_QUERY + step_t'(1): begin
        c.fol_load = 1'b1;
        c.done     = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/illa_link_ram.sv
// Link table memory: one write and one registered read per cycle, per-entry written bits.
module illa_link_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_all_i,
  input  logic                  we_i,
  input  illa_pkg::idx_t        waddr_i,
  input  illa_pkg::link_t       wdata_i,
  input  logic                  re_i,
  input  illa_pkg::idx_t        raddr_i,
  output illa_pkg::link_t       rdata_o,
  output logic                  rwritten_o
);

  illa_pkg::link_t                 mem_q [illa_pkg::ENTRIES];
  logic [illa_pkg::ENTRIES-1:0]    written_q;
  illa_pkg::link_t                 rdata_q;
  logic                            rwritten_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // unwritten entries read back as their reset link, supplied by the user
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (clear_all_i) begin
        written_q <= '0;
      end else if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rwritten_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o    = rdata_q;
  assign rwritten_o = rwritten_q;

endmodule

### hw/rtl/illa_seq.sv
// Microcode sequencer: step counter, program lookup and conditional exit.
module illa_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  illa_pkg::cmd_e   cmd_i,
  input  illa_pkg::flags_t flags_i,
  input  logic             slot_free_i,
  output illa_pkg::ctrl_t  ctrl_o,
  output illa_pkg::seq_t   seq_o,
  output logic             busy_o
);

  illa_pkg::step_t pc_q, pc_d;
  logic            busy_q, busy_d;
  illa_pkg::ctrl_t ctrl;
  logic            fail;
  logic            is_end;
  logic            go;
  illa_pkg::status_e status;

  always_comb begin
    ctrl   = illa_pkg::ucode_word(pc_q);
    fail   = 1'b0;
    status = illa_pkg::ST_OK;
    case (ctrl.chk)
      illa_pkg::CHK_FREE_EMPTY: begin
        fail   = flags_i.fh_nil;
        status = flags_i.fh_nil ? illa_pkg::ST_NO_FREE : illa_pkg::ST_OK;
      end
      illa_pkg::CHK_BAD_RELEASE, illa_pkg::CHK_BAD_QUERY: begin
        fail   = flags_i.entry_bad;
        status = flags_i.entry_bad ? illa_pkg::ST_BAD_ENTRY : illa_pkg::ST_OK;
      end
      default: begin
        fail   = 1'b0;
        status = illa_pkg::ST_OK;
      end
    endcase
    is_end = ctrl.done | fail;
    // the last step waits for a free output slot
    go     = busy_q & (~is_end | slot_free_i);
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = illa_pkg::entry_step(cmd_i);
    end else if (go) begin
      if (is_end) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + illa_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= illa_pkg::STEP_REINIT;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o        = ctrl;
  assign seq_o.exec    = go & ~fail;
  assign seq_o.finish  = go & is_end;
  assign seq_o.fail    = fail;
  assign seq_o.status  = status;
  assign busy_o        = busy_q;

endmodule

### hw/rtl/illa_datapath.sv
// Datapath: list heads, in-use marks, working entry and the two link tables.
module illa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [illa_pkg::ID_W-1:0]    entry_id_i,
  input  illa_pkg::ctrl_t              ctrl_i,
  input  illa_pkg::seq_t               seq_i,
  output illa_pkg::flags_t             flags_o,
  output illa_pkg::res_t               res_o
);

  localparam illa_pkg::idx_t LAST_IDX = illa_pkg::IDX_W'(illa_pkg::ENTRIES - 1);

  logic [illa_pkg::ID_W-1:0]      id_q;
  illa_pkg::idx_t                 e_q, e_d;
  illa_pkg::link_t                fh_q, fh_d;
  illa_pkg::link_t                ah_q, ah_d;
  logic [illa_pkg::ENTRIES-1:0]   use_q, use_d;

  logic            re;
  illa_pkg::link_t nx_raw, pv_raw;
  logic            nx_wr, pv_wr;
  illa_pkg::link_t n_link, p_link;
  illa_pkg::link_t e_link;
  logic            is_head;
  logic            id_ok;

  logic            nx_we;
  illa_pkg::idx_t  nx_waddr;
  illa_pkg::link_t nx_wdata;
  logic            pv_we;
  illa_pkg::link_t pv_target;
  illa_pkg::link_t pv_wdata;
  illa_pkg::link_t following;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      id_q <= entry_id_i;
    end
    e_q <= e_d;
  end

  assign id_ok  = 32'(id_q) < 32'(illa_pkg::ENTRIES);
  assign e_link = illa_pkg::LINK_W'(e_q);
  assign is_head = (ah_q == e_link);

  always_comb begin
    e_d = e_q;
    re  = 1'b0;
    if (seq_i.exec) begin
      case (ctrl_i.e_src)
        illa_pkg::E_FH: begin
          e_d = illa_pkg::IDX_W'(fh_q);
          re  = 1'b1;
        end
        illa_pkg::E_ID: begin
          e_d = illa_pkg::IDX_W'(id_q);
          re  = 1'b1;
        end
        default: begin
          e_d = e_q;
          re  = 1'b0;
        end
      endcase
    end
  end

  // read address is e_d, so e_q names the entry the read data belongs to
  assign n_link = nx_wr ? nx_raw
                : (e_q == LAST_IDX) ? illa_pkg::NIL_LINK : e_link + illa_pkg::LINK_W'(1);
  assign p_link = pv_wr ? pv_raw
                : (e_q == '0) ? illa_pkg::NIL_LINK : e_link - illa_pkg::LINK_W'(1);

  always_comb begin
    nx_waddr = e_q;
    nx_we    = ctrl_i.nx_we & seq_i.exec;
    case (ctrl_i.nx_addr)
      illa_pkg::NXA_P: begin
        nx_waddr = illa_pkg::IDX_W'(p_link);
        nx_we    = nx_we & (p_link < illa_pkg::NIL_LINK) & ~is_head;
      end
      default: begin
        nx_waddr = e_q;
      end
    endcase
    case (ctrl_i.nx_data)
      illa_pkg::NXD_AH: nx_wdata = ah_q;
      illa_pkg::NXD_FH: nx_wdata = fh_q;
      default:          nx_wdata = n_link;
    endcase
  end

  always_comb begin
    case (ctrl_i.pv_addr)
      illa_pkg::PVA_E:  pv_target = e_link;
      illa_pkg::PVA_AH: pv_target = ah_q;
      illa_pkg::PVA_FH: pv_target = fh_q;
      default:          pv_target = n_link;
    endcase
    // writes aimed at the nil link are dropped
    pv_we = ctrl_i.pv_we & seq_i.exec & (pv_target < illa_pkg::NIL_LINK);
    case (ctrl_i.pv_data)
      illa_pkg::PVD_E:        pv_wdata = e_link;
      illa_pkg::PVD_P_OR_NIL: pv_wdata = is_head ? illa_pkg::NIL_LINK : p_link;
      default:                pv_wdata = illa_pkg::NIL_LINK;
    endcase
  end

  illa_link_ram u_next_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_all_i (ctrl_i.links_clear & seq_i.exec),
    .we_i        (nx_we),
    .waddr_i     (nx_waddr),
    .wdata_i     (nx_wdata),
    .re_i        (re),
    .raddr_i     (e_d),
    .rdata_o     (nx_raw),
    .rwritten_o  (nx_wr)
  );

  illa_link_ram u_prev_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_all_i (ctrl_i.links_clear & seq_i.exec),
    .we_i        (pv_we),
    .waddr_i     (illa_pkg::IDX_W'(pv_target)),
    .wdata_i     (pv_wdata),
    .re_i        (1'b0 | re),
    .raddr_i     (e_d),
    .rdata_o     (pv_raw),
    .rwritten_o  (pv_wr)
  );

  always_comb begin
    fh_d  = fh_q;
    ah_d  = ah_q;
    use_d = use_q;
    if (seq_i.exec) begin
      case (ctrl_i.fh_op)
        illa_pkg::FH_N:    fh_d = n_link;
        illa_pkg::FH_E:    fh_d = e_link;
        illa_pkg::FH_ZERO: fh_d = '0;
        default:           fh_d = fh_q;
      endcase
      case (ctrl_i.ah_op)
        illa_pkg::AH_E:         ah_d = e_link;
        illa_pkg::AH_N_IF_HEAD: ah_d = is_head ? n_link : ah_q;
        illa_pkg::AH_NIL:       ah_d = illa_pkg::NIL_LINK;
        default:                ah_d = ah_q;
      endcase
      case (ctrl_i.use_op)
        illa_pkg::USE_SET:       use_d[e_q] = 1'b1;
        illa_pkg::USE_CLEAR:     use_d[e_q] = 1'b0;
        illa_pkg::USE_CLEAR_ALL: use_d = '0;
        default:                 use_d = use_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q  <= '0;
      ah_q  <= illa_pkg::NIL_LINK;
      use_q <= '0;
    end else begin
      fh_q  <= fh_d;
      ah_q  <= ah_d;
      use_q <= use_d;
    end
  end

  assign flags_o.fh_nil    = ~(fh_q < illa_pkg::NIL_LINK);
  assign flags_o.entry_bad = ~id_ok | ~use_q[illa_pkg::IDX_W'(id_q)];

  always_comb begin
    following = '0;
    if (seq_i.fail && ctrl_i.chk == illa_pkg::CHK_BAD_QUERY) begin
      following = illa_pkg::NIL_LINK;
    end else if (ctrl_i.fol_load) begin
      following = n_link;
    end
  end

  assign res_o.status    = seq_i.status;
  assign res_o.granted   = (ctrl_i.grant && !seq_i.fail) ? illa_pkg::GRANT_W'(e_q) : '0;
  assign res_o.list_head = illa_pkg::HEAD_W'(ah_d);
  assign res_o.following = illa_pkg::FOLLOW_W'(following);

endmodule

### hw/rtl/indexed_linked_list_allocator.sv
// Top level of the indexed doubly linked list allocator.
//
// Sixteen entries sit on two doubly linked lists, free and active. One command
// per input transfer: reinitialise, allocate, release an entry, or query an
// entry's next link; each command yields exactly one result transfer carrying
// status, granted entry, active list head and following link.
// A command runs as its microcode program; allocate, release and query end
// at their first step when its check fails. One control word runs per cycle
// over one write port on each link table, save that the last step waits for
// a free output slot, and one command is in work at a time: s_tready rises
// as the result enters the output register.
// Reset leaves all entries free in index order and the active list empty;
// the link tables need no clearing pass.
// The output register holds a result until it is taken. Meanwhile a new
// command may be accepted and run up to its last step, which then waits.
module indexed_linked_list_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // [1:0] command, [5:2] entry_id, [7:6] zero
  input  logic [illa_pkg::IN_DATA_W-1:0]      s_tdata_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // [1:0] status, [5:2] granted_entry, [10:6] list_head, [15:11] following_entry
  output logic [illa_pkg::OUT_DATA_W-1:0]     m_tdata_o
);

  logic             busy;
  logic             start;
  logic             slot_free;
  illa_pkg::ctrl_t  ctrl;
  illa_pkg::seq_t   seq;
  illa_pkg::flags_t flags;
  illa_pkg::res_t   res;

  logic                               m_valid_q;
  logic [illa_pkg::OUT_DATA_W-1:0]    m_data_q;

  assign s_tready_o = ~busy;
  assign start      = s_tvalid_i & ~busy;
  assign slot_free  = ~m_valid_q | m_tready_i;

  illa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (illa_pkg::cmd_e'(s_tdata_i[illa_pkg::CMD_W-1:0])),
    .flags_i     (flags),
    .slot_free_i (slot_free),
    .ctrl_o      (ctrl),
    .seq_o       (seq),
    .busy_o      (busy)
  );

  illa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .entry_id_i (s_tdata_i[illa_pkg::CMD_W +: illa_pkg::ID_W]),
    .ctrl_i     (ctrl),
    .seq_i      (seq),
    .flags_o    (flags),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (seq.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.finish) begin
      m_data_q <= res;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // one command in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input accepted while a command is in work");

  // a result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("pending result lost");

  // active head is an entry or nil
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[10:6] <= illa_pkg::HEAD_W'(illa_pkg::ENTRIES))
    else $error("list head out of range");

  // failed allocate grants nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[1:0] == illa_pkg::ST_NO_FREE |-> m_tdata_o[5:2] == '0)
    else $error("granted entry on failed allocate");

endmodule
